/* sv/dbd_pkg.sv */
package dbd_pkg;

  typedef logic [26:0]        date_t;
  typedef logic signed [22:0] count_t;
  typedef logic [2:0]         status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FIN1,
    ST_FIN2
  } state_t;

  // divide jobs, run in this order for each pair of dates
  typedef logic [2:0] job_t;
  localparam job_t JOB_SDATE  = 3'd0;  // start word / 10000
  localparam job_t JOB_SMONTH = 3'd1;  // start mmdd / 100
  localparam job_t JOB_SYEAR  = 3'd2;  // start year / 100
  localparam job_t JOB_EDATE  = 3'd3;
  localparam job_t JOB_EMONTH = 3'd4;
  localparam job_t JOB_EYEAR  = 3'd5;

  localparam logic [26:0] DIV_YEAR = 27'd10000;
  localparam logic [26:0] DIV_CENT = 27'd100;

  // quotient = (x * recip) >> shift, exact for a 27-bit word and a 14-bit mmdd or year
  localparam logic [26:0] RECIP_YEAR = 27'd109951163;  // ceil(2^40 / 10000)
  localparam logic [26:0] RECIP_CENT = 27'd20972;      // ceil(2^21 / 100)

  localparam status_t STAT_OK       = 3'd0;
  localparam status_t STAT_FEB30    = 3'd1;
  localparam status_t STAT_START_29 = 3'd2;
  localparam status_t STAT_END_29   = 3'd3;
  localparam status_t STAT_ORDER    = 3'd4;

endpackage

/* sv/days_between_dates.sv */
// Signed day count between two Gregorian dates, each given as a decimal
// word mmddyyyy. A single shared multiplier splits each date by 10000, the
// mmdd part by 100 and the year by 100, each split as a reciprocal multiply
// for the quotient, then quotient times divisor for the remainder. ST_FIN1
// then registers the day figures and leap counts, and ST_FIN2 forms the
// final sum. in_stall stays high from acceptance until the result is
// loaded into the output register; a result waiting there does not hold off
// the next word, but a stalled output register delays the load by the length
// of the stall. On any status other than zero the count is zero.
// Months and days outside the calendar are not checked.
module days_between_dates (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  dbd_pkg::date_t   in_start_date,
  input  dbd_pkg::date_t   in_end_date,
  output logic             out_valid,
  input  logic             out_stall,
  output dbd_pkg::count_t  out_day_count,
  output dbd_pkg::status_t out_status
);
  import dbd_pkg::*;

  state_t state_r, state_nxt;
  job_t   job_r;
  logic        step_r;
  logic [13:0] quo_r;
  logic [26:0] div_r;
  date_t       ev_r;

  logic [13:0] ys_r, ye_r;
  logic [7:0]  ms_r, me_r;
  logic [6:0]  ds_r, de_r;
  logic [6:0]  yhs_r, yhe_r;  // year / 100
  logic [6:0]  yls_r, yle_r;  // year % 100

  logic signed [15:0] fs_r, fe_r;
  logic        leap_s_r;
  logic [13:0] ls_r, le_r;
  status_t     stat_r;

  logic    out_valid_r;
  count_t  out_day_count_r;
  status_t out_status_r;

  logic accept, step_en, fin1_en, deliver;

  logic        wide_job;
  logic        step_done;
  logic [26:0] mul_a, mul_b;
  logic [53:0] prod;
  logic [13:0] quo_step;
  logic [26:0] rem_full;
  logic [13:0] rem_step;
  logic [26:0] next_load;

  // ---------------------------------------------------------------- helpers
  function automatic logic is_leap(input logic [13:0] y, input logic [6:0] r100,
                                   input logic [6:0] q100);
    is_leap = (r100 != 7'd0) ? (y[1:0] == 2'd0) : (q100[1:0] == 2'd0);
  endfunction

  // long months strictly before month m, capped at December
  function automatic logic [2:0] long_before(input logic [7:0] m);
    logic [2:0] n;
    n = 3'd0;
    if (m >= 8'd13) begin
      n = 3'd7;
    end else begin
      unique case (m[3:0])
        4'd2, 4'd3:   n = 3'd1;
        4'd4, 4'd5:   n = 3'd2;
        4'd6, 4'd7:   n = 3'd3;
        4'd8:         n = 3'd4;
        4'd9, 4'd10:  n = 3'd5;
        4'd11, 4'd12: n = 3'd6;
        default:      n = 3'd0;
      endcase
    end
    long_before = n;
  endfunction

  function automatic logic signed [15:0] day_fig(input logic [7:0] m, input logic [6:0] d,
                                                 input logic leap);
    logic [15:0] n;
    n = {8'd0, m} * 16'd30 + {9'd0, d} - 16'd30 + {13'd0, long_before(m)};
    if (m > 8'd2) begin
      n = n - (leap ? 16'd1 : 16'd2);
    end
    day_fig = $signed(n);
  endfunction

  // ---------------------------------------------------------------- control
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_DIV;
      ST_DIV: begin
        if (step_done && job_r == JOB_EYEAR) state_nxt = ST_FIN1;
      end
      ST_FIN1: state_nxt = ST_FIN2;
      ST_FIN2: if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    accept   = 1'b0;
    step_en  = 1'b0;
    fin1_en  = 1'b0;
    deliver  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
      end
      ST_DIV:  step_en = 1'b1;
      ST_FIN1: fin1_en = 1'b1;
      ST_FIN2: deliver = !out_valid_r || !out_stall;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------- divider
  assign wide_job  = (job_r == JOB_SDATE) || (job_r == JOB_EDATE);
  assign step_done = step_r;

  // first step: operand times reciprocal; second step: quotient times divisor
  assign mul_a    = step_r ? {13'd0, quo_r} : div_r;
  assign mul_b    = step_r ? (wide_job ? DIV_YEAR : DIV_CENT)
                           : (wide_job ? RECIP_YEAR : RECIP_CENT);
  assign prod     = {27'd0, mul_a} * {27'd0, mul_b};
  assign quo_step = wide_job ? prod[53:40] : prod[34:21];
  assign rem_full = div_r - prod[26:0];
  assign rem_step = rem_full[13:0];

  // operand of the job that follows the one finishing now
  always_comb begin
    unique case (job_r)
      JOB_SDATE:  next_load = {13'd0, quo_r};
      JOB_SMONTH: next_load = {13'd0, ys_r};
      JOB_SYEAR:  next_load = ev_r;
      JOB_EDATE:  next_load = {13'd0, quo_r};
      JOB_EMONTH: next_load = {13'd0, ye_r};
      default:    next_load = div_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r  <= JOB_SDATE;
      step_r <= 1'b0;
    end else if (accept) begin
      job_r  <= JOB_SDATE;
      step_r <= 1'b0;
    end else if (step_en) begin
      if (step_done) begin
        job_r <= job_r + 3'd1;
      end
      step_r <= !step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      div_r <= in_start_date;
      ev_r  <= in_end_date;
    end else if (step_en) begin
      if (!step_done) begin
        quo_r <= quo_step;
      end else begin
        div_r <= next_load;
        unique case (job_r)
          JOB_SDATE:  ys_r <= rem_step;
          JOB_SMONTH: begin
            ds_r <= rem_step[6:0];
            ms_r <= quo_r[7:0];
          end
          JOB_SYEAR: begin
            yls_r <= rem_step[6:0];
            yhs_r <= quo_r[6:0];
          end
          JOB_EDATE:  ye_r <= rem_step;
          JOB_EMONTH: begin
            de_r <= rem_step[6:0];
            me_r <= quo_r[7:0];
          end
          default: begin
            yle_r <= rem_step[6:0];
            yhe_r <= quo_r[6:0];
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- finish
  logic        leap_s, leap_e;
  logic [13:0] ye_m1;
  logic [6:0]  he_m1;
  status_t     stat_c;

  assign leap_s = is_leap(ys_r, yls_r, yhs_r);
  assign leap_e = is_leap(ye_r, yle_r, yhe_r);
  assign ye_m1  = ye_r - 14'd1;
  assign he_m1  = (yle_r == 7'd0) ? yhe_r - 7'd1 : yhe_r;

  always_comb begin
    priority if ((ms_r == 8'd2 && ds_r == 7'd30) || (me_r == 8'd2 && de_r == 7'd30)) begin
      stat_c = STAT_FEB30;
    end else if (ms_r == 8'd2 && ds_r == 7'd29 && !leap_s) begin
      stat_c = STAT_START_29;
    end else if (me_r == 8'd2 && de_r == 7'd29 && !leap_e) begin
      stat_c = STAT_END_29;
    end else if (ys_r > ye_r) begin
      stat_c = STAT_ORDER;
    end else begin
      stat_c = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (fin1_en) begin
      fs_r     <= day_fig(ms_r, ds_r, leap_s);
      fe_r     <= day_fig(me_r, de_r, leap_e);
      leap_s_r <= leap_s;
      // leap years in 1..n as n/4 - n/100 + n/400
      ls_r     <= {2'd0, ys_r[13:2]} - {7'd0, yhs_r} + {9'd0, yhs_r[6:2]};
      le_r     <= {2'd0, ye_m1[13:2]} - {7'd0, he_m1} + {9'd0, he_m1[6:2]};
      stat_r   <= stat_c;
    end
  end

  logic [13:0]        span;
  logic [22:0]        full;
  logic signed [24:0] fs_x, fe_x, days_span, days_c;

  assign span = ye_r - ys_r - 14'd1;
  assign full = {9'd0, span} * 23'd365;
  assign fs_x = {{9{fs_r[15]}}, fs_r};
  assign fe_x = {{9{fe_r[15]}}, fe_r};
  assign days_span = $signed({2'd0, full}) + $signed({11'd0, le_r}) - $signed({11'd0, ls_r})
                   + (leap_s_r ? 25'sd366 : 25'sd365) - fs_x + fe_x;

  always_comb begin
    priority if (stat_r != STAT_OK) begin
      days_c = 25'sd0;
    end else if (ys_r < ye_r) begin
      days_c = days_span;
    end else begin
      days_c = fe_x - fs_x;
    end
  end

  // ---------------------------------------------------------------- output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (deliver) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (deliver) begin
      out_day_count_r <= days_c[22:0];
      out_status_r    <= stat_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_day_count = out_day_count_r;
  assign out_status    = out_status_r;

endmodule
